// ===== hw/rtl/gns_pkg.sv =====
// Package for the sum-of-uniforms Gaussian noise generator.
// Holds the generator constants, register indexes and the controller command struct.
// No dependencies.
package gns_pkg;

	localparam int MAX_COUNT = 64;
	localparam int CNT_W     = 7;
	localparam int TERMS     = 12;
	localparam int TERM_W    = 4;
	localparam int LCG_W     = 16;
	localparam int SUM_W     = 20;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;
	localparam int STD_W     = 31;

	localparam logic [11:0]      LCG_MUL  = 12'd2053;
	localparam logic [LCG_W-1:0] LCG_ADD  = 16'd13849;
	localparam logic [20:0]      SIX_Q16  = 21'd393216;
	localparam logic [STD_W-1:0] STD_RST  = 31'd65536;

	localparam logic [CFG_IDX_W-1:0] REG_MEAN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STD_DEV = 2'd1;

	typedef struct packed {
		logic load;
		logic step;
		logic mul;
		logic fin;
		logic last;
	} cmd_t;

endpackage

// ===== hw/rtl/gns_datapath.sv =====
// Datapath: config registers, LCG, uniform accumulator, scale multiply, round and saturate.
// Depends on gns_pkg; driven by gns_ctrl commands.
module gns_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gns_pkg::cmd_t                 cmd,
	input  logic [gns_pkg::LCG_W-1:0]     seed,
	input  logic                          cfg_we,
	input  logic [gns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gns_pkg::CFG_W-1:0]     cfg_data,
	output logic signed [31:0]            sample,
	output logic                          last
);
	import gns_pkg::*;

	logic signed [31:0] mean_q;
	logic [STD_W-1:0]   std_dev_q;
	logic [LCG_W-1:0]   lcg_q;
	logic [SUM_W-1:0]   sum_q;
	logic signed [52:0] prod_s1;
	logic signed [31:0] sample_q;
	logic               last_q;

	logic [27:0]        lcg_mul;
	logic [LCG_W-1:0]   lcg_next;
	logic signed [20:0] centred;
	logic signed [52:0] prod;
	logic signed [55:0] biased;
	logic signed [39:0] total;
	logic signed [31:0] sat;

	assign lcg_mul  = lcg_q * LCG_MUL;
	assign lcg_next = lcg_mul[LCG_W-1:0] + LCG_ADD;
	assign centred  = $signed({1'b0, sum_q} - SIX_Q16);
	assign prod     = 53'(centred) * $signed({22'd0, std_dev_q});
	// mean folded in above the binary point, half-LSB added for rounding
	assign biased   = 56'(prod_s1) + $signed({{8{mean_q[31]}}, mean_q, 16'h8000});
	assign total    = biased[55:16];

	always_comb begin
		if (total[39:31] == {9{total[31]}}) begin
			sat = total[31:0];
		end else if (total[39]) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = 32'sh7fff_ffff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q    <= '0;
			std_dev_q <= STD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MEAN:    mean_q    <= cfg_data;
				REG_STD_DEV: std_dev_q <= cfg_data[STD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lcg_q <= seed;
			sum_q <= '0;
		end else if (cmd.step) begin
			lcg_q <= lcg_next;
			sum_q <= sum_q + {4'd0, lcg_next};
		end else if (cmd.mul) begin
			sum_q <= '0;
		end
		if (cmd.mul) begin
			prod_s1 <= prod;
		end
		if (cmd.fin) begin
			sample_q <= sat;
			last_q   <= cmd.last;
		end
	end

	assign sample = sample_q;
	assign last   = last_q;

endmodule

// ===== hw/rtl/gns_ctrl.sv =====
// Controller: sequences LCG steps, multiply, finish and output beat per sample.
// Depends on gns_pkg; issues cmd_t to gns_datapath.
module gns_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [gns_pkg::CNT_W-1:0] count,
	output logic                      out_valid,
	input  logic                      out_ready,
	output gns_pkg::cmd_t             cmd
);
	import gns_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GEN,
		ST_MUL,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t            state_q;
	logic [TERM_W-1:0] term_q;
	logic [CNT_W-1:0]  left_q;
	logic [CNT_W-1:0]  count_sat;

	assign count_sat = (count > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : count;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd      = '0;
		cmd.load = in_ready && in_valid;
		cmd.step = (state_q == ST_GEN);
		cmd.mul  = (state_q == ST_MUL);
		cmd.fin  = (state_q == ST_FIN);
		cmd.last = (left_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			term_q  <= '0;
			left_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && count != '0) begin
						left_q  <= count_sat;
						term_q  <= '0;
						state_q <= ST_GEN;
					end
				end
				ST_GEN: begin
					term_q <= term_q + 1'b1;
					if (term_q == TERM_W'(TERMS - 1)) begin
						term_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					left_q  <= left_q - 1'b1;
					state_q <= ST_FIN;
				end
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_ready) begin
						state_q <= (left_q == '0) ? ST_IDLE : ST_GEN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output beats overlap");
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= CNT_W'(MAX_COUNT))
		else $error("sample counter out of range");
	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GEN |-> term_q < TERM_W'(TERMS))
		else $error("term index out of range");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && count != '0 |=> state_q == ST_GEN && left_q != '0)
		else $error("request with samples did not start");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && out_ready && cmd.last |=> state_q == ST_IDLE)
		else $error("final beat did not return to idle");
`endif

endmodule

// ===== hw/rtl/gaussian_noise_sum_of_uniforms.sv =====
// Sum-of-12-uniforms Gaussian noise generator, top level.
// Each sample runs one LCG step per uniform term, then the multiply, finish and output beat states.
// The single LCG steps once a cycle while terms are summed; an output stall holds the next sample.
// A new request is taken only when idle, after the last sample beat of the previous one is accepted.
// Reset (arst_n, async): controller idle, mean = 0, std_dev = 1.0.
module gaussian_noise_sum_of_uniforms (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gns_pkg::LCG_W-1:0]     seed,
	input  logic [gns_pkg::CNT_W-1:0]     count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            sample,
	output logic                          last,
	input  logic                          cfg_we,
	input  logic [gns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gns_pkg::CFG_W-1:0]     cfg_data
);
	import gns_pkg::*;

	cmd_t cmd;

	gns_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.count     (count),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	gns_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.seed      (seed),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.last      (last)
	);

endmodule
